// ===== rtl/slis_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list package
// Shared codes, widths and types for the sorted insert and search core.
// ----------------------------------------------------------------------------
`default_nettype none

package slis_pkg;

    localparam int ValueW = 32;
    localparam int GroupW = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic signed [ValueW-1:0] value_t;

    typedef struct packed {
        logic accept;
        logic insert_en;
    } slis_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/slis_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one table entry, compares it with the incoming value and takes
// either the new value or its left neighbour's entry when an insert shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module slis_cell
    import slis_pkg::*;
(
    input  wire logic            clk,
    input  wire slis_cell_ctrl_t ctrl,
    input  wire value_t          value,
    input  wire logic            occupied,
    input  wire value_t          left_entry,
    input  wire logic            left_lt,
    output value_t               entry,
    output logic                 lt,
    output logic                 eq_flag
);

    value_t entry_reg;
    value_t entry_next;
    logic   eq_reg;
    logic   eq_next;
    logic   eq;

    assign lt = occupied && (entry_reg < value);
    assign eq = occupied && (entry_reg == value);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en && !lt)
        begin
            entry_next = left_lt ? value : left_entry;
        end
        eq_next = ctrl.accept ? eq : eq_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        eq_reg    <= eq_next;
    end

    assign entry   = entry_reg;
    assign eq_flag = eq_reg;

endmodule

`default_nettype wire

// ===== rtl/slis_or_tree.sv =====
// ----------------------------------------------------------------------------
// Sorted list match reducer
// Registered two-level OR of the per-cell match flags.
// ----------------------------------------------------------------------------
`default_nettype none

module slis_or_tree
    import slis_pkg::*;
#(
    parameter int N = 16
)
(
    input  wire logic         clk,
    input  wire logic [N-1:0] flags,
    output logic              hit
);

    localparam int NG = (N + GroupW - 1) / GroupW;

    logic [NG-1:0] group_reg;

    for (genvar g = 0; g < NG; g++)
    begin : g_group
        localparam int LO = g * GroupW;
        localparam int HI = ((LO + GroupW) < N) ? (LO + GroupW - 1) : (N - 1);

        always_ff @(posedge clk)
        begin
            group_reg[g] <= |flags[HI:LO];
        end
    end

    assign hit = |group_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_search_core.sv =====
// ----------------------------------------------------------------------------
// Sorted list insert and search core
// Ascending table of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry command and value. Command insert
// places the value before any equal entries; command search looks it up.
// Output channel: out_valid/out_ready carry found and status, one item per
// input item, in order.
// Every cell compares its entry with the value in the cycle of acceptance
// and an insert shifts the entries not below the value one cell up in that same edge.
// The per-cell match flags are held in a match register and then pass a
// registered OR tree; the result is loaded into the output register. The
// core takes one item at a time: a new item is accepted only after the
// previous item's result has been loaded into the output register.
// A full table drops the insert and reports status full.
// Reset empties the table at once; no clearing pass is needed.
// If the receiver stalls, the result waits in the output register while the
// next item is already accepted and processed; that item's result is held
// back until the register is free, and no further item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_search_core
    import slis_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire logic   command,
    input  wire value_t value,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        found,
    output logic        status
);

    localparam int CountW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   count_next;
    logic                cmd_reg;
    logic                cmd_next;
    logic                full_reg;
    logic                full_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                found_reg;
    logic                found_next;
    logic                status_reg;
    logic                status_next;

    logic                accept;
    logic                full;
    logic                hit;
    slis_cell_ctrl_t     cell_ctrl;
    value_t              entries [CAPACITY];
    logic [CAPACITY-1:0] lts;
    logic [CAPACITY-1:0] eqs;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CountW'(CAPACITY));

    assign cell_ctrl = '{accept:    accept,
                         insert_en: accept && (command == CMD_INSERT) && !full};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        value_t left_entry;
        logic   left_lt;

        if (i == 0)
        begin : g_first
            assign left_entry = value;
            assign left_lt    = 1'b0;
        end
        else
        begin : g_rest
            assign left_entry = entries[i-1];
            assign left_lt    = lts[i-1];
        end

        slis_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .value      (value),
            .occupied   (count_reg > CountW'(i)),
            .left_entry (left_entry),
            .left_lt    (left_lt),
            .entry      (entries[i]),
            .lt         (lts[i]),
            .eq_flag    (eqs[i])
        );
    end

    slis_or_tree #(
        .N (CAPACITY)
    ) u_or_tree (
        .clk   (clk),
        .flags (eqs),
        .hit   (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    full_next  = full;
                    state_next = S_REDUCE;
                    if (cell_ctrl.insert_en)
                    begin
                        count_next = count_reg + CountW'(1);
                    end
                end
            end
            S_REDUCE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = (cmd_reg == CMD_SEARCH) && hit;
                    status_next    = ((cmd_reg == CMD_INSERT) && full_reg) ?
                                     STATUS_FULL : STATUS_DONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmd_reg       <= CMD_INSERT;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= STATUS_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmd_reg       <= cmd_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== rtl/slis_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted list port checker
// Checks the timing and result rules seen on the core's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module slis_checker
    import slis_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_valid,
    input wire logic   in_ready,
    input wire logic   out_valid,
    input wire logic   out_ready,
    input wire logic   found,
    input wire logic   status
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
    else $error("core took a new item while one was in progress");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##3 out_valid)
    else $error("no result three cycles after an accepted item");

    a_found_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STATUS_DONE)
    else $error("result reports a match together with a full table");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status))
    else $error("stalled result changed or vanished");

endmodule

bind sorted_list_insert_search_core slis_checker u_slis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .status    (status)
);

`default_nettype wire
